// File: rtl/stcc_pkg.sv
// stcc_pkg: shared types, item kinds and box extent constants for the
// sprite table collision check block; no dependencies
`default_nettype none
package stcc_pkg;

	localparam int SPRITE_COUNT_DEF = 64;

	localparam logic [1:0] KIND_SET_POS   = 2'd0;
	localparam logic [1:0] KIND_SET_TYPE  = 2'd1;
	localparam logic [1:0] KIND_SET_SHOW  = 2'd2;
	localparam logic [1:0] KIND_QUERY     = 2'd3;

	localparam logic [15:0] EXT_NARROW = 16'd7;
	localparam logic [15:0] EXT_WIDE   = 16'd15;

	typedef struct packed {
		logic [1:0]  kind;
		logic [5:0]  sprite_a;
		logic [5:0]  sprite_b;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [2:0]  size_type;
		logic        show;
	} stcc_item_t;

	typedef struct packed {
		logic collide;
		logic bad_type;
	} stcc_result_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic evaluate;
	} stcc_cmd_t;

	function automatic logic [15:0] box_end(input logic [15:0] pos, input logic wide);
		box_end = pos + (wide ? EXT_WIDE : EXT_NARROW);
	endfunction

endpackage
`default_nettype wire

// File: rtl/stcc_ctrl.sv
// stcc_ctrl: sequencer for one item at a time (capture, execute, evaluate)
// depends on stcc_pkg for the command struct
`default_nettype none
module stcc_ctrl
	import stcc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	output logic           busy,
	output stcc_cmd_t      cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_EVAL = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.evaluate = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule
`default_nettype wire

// File: rtl/stcc_dp.sv
// stcc_dp: sprite table storage, dual read, box ends and overlap compares
// depends on stcc_pkg for item, result and command types
`default_nettype none
module stcc_dp
	import stcc_pkg::*;
#(
	parameter int SPRITE_COUNT = SPRITE_COUNT_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire stcc_cmd_t  cmd,
	input  wire stcc_item_t item,
	output logic            done,
	output stcc_result_t    result
);

	localparam int AW = $clog2(SPRITE_COUNT);
	localparam int IW = ((AW > 6) ? AW : 6) + 1;

	stcc_item_t item_q;

	logic [31:0] pos_mem [SPRITE_COUNT];
	logic [2:0]  type_mem [SPRITE_COUNT];

	logic [SPRITE_COUNT-1:0] vis_q;
	logic [SPRITE_COUNT-1:0] pos_vld_q;
	logic [SPRITE_COUNT-1:0] type_vld_q;

	logic [IW-1:0] a_ext, b_ext;
	logic [AW-1:0] a_idx, b_idx;
	logic          a_ok, b_ok;

	logic [31:0] pos_a_s1, pos_b_s1;
	logic [2:0]  type_a_s1, type_b_s1;
	logic        vis_a_s1, vis_b_s1;
	logic        pvld_a_s1, pvld_b_s1;
	logic        tvld_a_s1, tvld_b_s1;
	logic        query_s1;

	logic [15:0] xa, ya, xb, yb;
	logic [2:0]  ta, tb;
	logic        ka, kb, ovl_x, ovl_y;
	stcc_result_t result_d;
	stcc_result_t result_q;
	logic         done_q;

	assign a_ext = IW'(item_q.sprite_a);
	assign b_ext = IW'(item_q.sprite_b);
	assign a_idx = a_ext[AW-1:0];
	assign b_idx = b_ext[AW-1:0];
	assign a_ok  = (a_ext < IW'(SPRITE_COUNT));
	assign b_ok  = (b_ext < IW'(SPRITE_COUNT));

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
	end

	// position and type stores, one write port and two read ports
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (a_ok && item_q.kind == KIND_SET_POS) begin
				pos_mem[a_idx] <= {item_q.pos_x, item_q.pos_y};
			end
			if (a_ok && item_q.kind == KIND_SET_TYPE) begin
				type_mem[a_idx] <= item_q.size_type;
			end
			pos_a_s1  <= pos_mem[a_idx];
			pos_b_s1  <= pos_mem[b_idx];
			type_a_s1 <= type_mem[a_idx];
			type_b_s1 <= type_mem[b_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vis_q      <= '0;
			pos_vld_q  <= '0;
			type_vld_q <= '0;
		end else if (cmd.exec && a_ok) begin
			case (item_q.kind)
				KIND_SET_POS:  pos_vld_q[a_idx]  <= 1'b1;
				KIND_SET_TYPE: type_vld_q[a_idx] <= 1'b1;
				KIND_SET_SHOW: vis_q[a_idx]      <= item_q.show;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			query_s1  <= (item_q.kind == KIND_QUERY);
			vis_a_s1  <= a_ok && vis_q[a_idx];
			vis_b_s1  <= b_ok && vis_q[b_idx];
			pvld_a_s1 <= pos_vld_q[a_idx];
			pvld_b_s1 <= pos_vld_q[b_idx];
			tvld_a_s1 <= type_vld_q[a_idx];
			tvld_b_s1 <= type_vld_q[b_idx];
		end
	end

	// entries never written read as zero
	always_comb begin
		{xa, ya} = pvld_a_s1 ? pos_a_s1 : 32'd0;
		{xb, yb} = pvld_b_s1 ? pos_b_s1 : 32'd0;
		ta = tvld_a_s1 ? type_a_s1 : 3'd0;
		tb = tvld_b_s1 ? type_b_s1 : 3'd0;
		ka = !ta[2];
		kb = !tb[2];
		ovl_x = (xa <= box_end(xb, tb[0])) && (xb <= box_end(xa, ta[0]));
		ovl_y = (ya <= box_end(yb, tb[1])) && (yb <= box_end(ya, ta[1]));
		result_d.bad_type = query_s1 && ((vis_a_s1 && !ka) || (vis_b_s1 && !kb));
		result_d.collide  = query_s1 && vis_a_s1 && vis_b_s1 && ka && kb
			&& ovl_x && ovl_y;
	end

	always_ff @(posedge clk) begin
		if (cmd.evaluate) begin
			result_q <= result_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.evaluate;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

// File: rtl/sprite_table_collision_check.sv
// sprite_table_collision_check: top level, sprite table with box collision query
// depends on stcc_pkg, stcc_ctrl and stcc_dp
//
// channels: an item is taken at a rising edge with start high and busy low.
// kind selects set position, set type, set visibility or a collision query
// of sprite_a against sprite_b. every item gives exactly one result.
// the result shows on result for one cycle with done high; the receiver
// cannot stall, so it must take it in that cycle.
// sequence: the item is captured, then the exec step accesses the table (a
// write for set position or set type, and two reads of the position and type
// stores), then the evaluate step adds box ends and compares; result and done
// are registered at the end of the evaluate step. busy is high during the exec
// and evaluate steps, so a new item is taken only after the capture, exec and
// evaluate steps of the sequencer have run for the last one.
// busy drops while done is up, so the next item can be taken in that cycle.
// reset: visibility, position and type valid bits clear at once, so every
// sprite reads as invisible at position zero and type zero; no clearing pass.
// sprite indexes at or above SPRITE_COUNT have no entry: writes to them are
// dropped and queries read them as invisible.
`default_nettype none
module sprite_table_collision_check
	import stcc_pkg::*;
#(
	parameter int SPRITE_COUNT = SPRITE_COUNT_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire stcc_item_t item,
	output logic            done,
	output stcc_result_t    result
);

	stcc_cmd_t cmd;

	stcc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	stcc_dp #(
		.SPRITE_COUNT (SPRITE_COUNT)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.done   (done),
		.result (result)
	);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a preceding busy item");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.collide && result.bad_type))
		else $error("collide and bad_type both set");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accepting an item");

	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.kind != KIND_QUERY) |=> ##2
		(done && !result.collide && !result.bad_type))
		else $error("write item gave a nonzero or missing result");

endmodule
`default_nettype wire

// File: tb/tb.sv
// tb: self-checking bench for sprite_table_collision_check, directed box edge,
// wrap and unknown type items, then shaped random traffic against a local table
// depends on stcc_pkg and the rtl top level
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import stcc_pkg::*;

	localparam int SLOTS       = SPRITE_COUNT_DEF;
	localparam int RAND_ITEMS  = 1500;
	localparam int CYCLE_LIMIT = 400000;

	localparam logic [2:0] ST_SQUARE = 3'd0;
	localparam logic [2:0] ST_WIDE   = 3'd1;
	localparam logic [2:0] ST_TALL   = 3'd2;
	localparam logic [2:0] ST_BIG    = 3'd3;
	localparam logic [2:0] ST_BAD    = 3'd7;

	logic         clk;
	logic         arst_n;
	logic         start;
	logic         busy;
	stcc_item_t   item;
	logic         done;
	stcc_result_t result;

	logic [15:0] tab_x    [SLOTS];
	logic [15:0] tab_y    [SLOTS];
	logic [2:0]  tab_type [SLOTS];
	logic        tab_vis  [SLOTS];

	stcc_result_t expected_results[$];
	stcc_result_t want;
	int error_count;
	int items_sent;
	int queries_sent;
	int hits_seen;
	int bad_seen;

	sprite_table_collision_check dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout with %0d results outstanding", expected_results.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [15:0] extent_x(input logic [2:0] t);
		return (t == ST_WIDE || t == ST_BIG) ? EXT_WIDE : EXT_NARROW;
	endfunction

	function automatic logic [15:0] extent_y(input logic [2:0] t);
		return (t == ST_TALL || t == ST_BIG) ? EXT_WIDE : EXT_NARROW;
	endfunction

	function automatic bit spans_overlap(input logic [15:0] pa, ea, pb, eb);
		logic [15:0] end_a;
		logic [15:0] end_b;
		end_a = pa + ea;
		end_b = pb + eb;
		return (pa <= end_b) && (pb <= end_a);
	endfunction

	// updates the local sprite table and returns the result the item should give
	function automatic stcc_result_t predict_result(input stcc_item_t it);
		stcc_result_t r;
		bit va, vb, ka, kb;
		int a, b;
		r = '0;
		a = it.sprite_a;
		b = it.sprite_b;
		case (it.kind)
		KIND_SET_POS: begin
			if (a < SLOTS) begin
				tab_x[a] = it.pos_x;
				tab_y[a] = it.pos_y;
			end
		end
		KIND_SET_TYPE: begin
			if (a < SLOTS)
				tab_type[a] = it.size_type;
		end
		KIND_SET_SHOW: begin
			if (a < SLOTS)
				tab_vis[a] = it.show;
		end
		default: begin
			va = (a < SLOTS) && tab_vis[a];
			vb = (b < SLOTS) && tab_vis[b];
			ka = va && (tab_type[a] <= ST_BIG);
			kb = vb && (tab_type[b] <= ST_BIG);
			r.bad_type = (va && !ka) || (vb && !kb);
			if (va && vb && ka && kb)
				r.collide = spans_overlap(tab_x[a], extent_x(tab_type[a]),
						tab_x[b], extent_x(tab_type[b])) &&
					spans_overlap(tab_y[a], extent_y(tab_type[a]),
						tab_y[b], extent_y(tab_type[b]));
		end
		endcase
		return r;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		else if (roll < 88)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic stcc_item_t build_item(input logic [1:0] kind, input logic [5:0] a, b,
			input logic [15:0] x, y, input logic [2:0] t, input logic s);
		stcc_item_t it;
		it.kind      = kind;
		it.sprite_a  = a;
		it.sprite_b  = b;
		it.pos_x     = x;
		it.pos_y     = y;
		it.size_type = t;
		it.show      = s;
		return it;
	endfunction

	function automatic logic [15:0] random_coord(input int mode);
		if (mode < 70)
			return 16'd1000 + 16'($urandom_range(0, 40));
		else if (mode < 85)
			return 16'hFFE0 + 16'($urandom_range(0, 31));
		return 16'($urandom_range(0, 65535));
	endfunction

	// mostly a handful of sprites packed close together, so queries often hit
	function automatic stcc_item_t random_item();
		stcc_item_t it;
		int roll;
		int mode;
		roll = $urandom_range(0, 99);
		mode = $urandom_range(0, 99);
		if (roll < 20)
			it.kind = KIND_SET_POS;
		else if (roll < 35)
			it.kind = KIND_SET_TYPE;
		else if (roll < 50)
			it.kind = KIND_SET_SHOW;
		else
			it.kind = KIND_QUERY;
		it.sprite_a  = ($urandom_range(0, 99) < 80) ? 6'($urandom_range(0, 7))
			: 6'($urandom_range(0, 63));
		it.sprite_b  = ($urandom_range(0, 99) < 80) ? 6'($urandom_range(0, 7))
			: 6'($urandom_range(0, 63));
		it.pos_x     = random_coord(mode);
		it.pos_y     = random_coord(mode);
		it.size_type = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 3))
			: 3'($urandom_range(4, 7));
		it.show      = ($urandom_range(0, 99) < 80);
		return it;
	endfunction

	task automatic send_item(input stcc_item_t it);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy !== 1'b0);
		expected_results.push_back(predict_result(it));
		items_sent++;
		if (it.kind == KIND_QUERY)
			queries_sent++;
	endtask

	task automatic stop_sending();
		@(negedge clk);
		start <= 1'b0;
	endtask

	task automatic wait_drained();
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result with no item pending");
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (result.collide !== want.collide) begin
					$error("collide: expected %0b, got %0b", want.collide, result.collide);
					error_count++;
				end
				if (result.bad_type !== want.bad_type) begin
					$error("bad_type: expected %0b, got %0b", want.bad_type, result.bad_type);
					error_count++;
				end
				if (result.collide === 1'b1)
					hits_seen++;
				if (result.bad_type === 1'b1)
					bad_seen++;
			end
		end
	end

	task automatic test_after_reset();
		send_item(build_item(KIND_QUERY, 6'd0, 6'd63, 16'hFFFF, 16'hFFFF, 3'd7, 1'b1));
		send_item(build_item(KIND_QUERY, 6'd5, 6'd5, 16'h0000, 16'h0000, 3'd0, 1'b0));
	endtask

	task automatic test_box_edges();
		send_item(build_item(KIND_SET_POS, 6'd0, 6'd63, 16'd100, 16'd200, ST_BAD, 1'b0));
		send_item(build_item(KIND_SET_TYPE, 6'd0, 6'd63, 16'hFFFF, 16'hFFFF, ST_SQUARE, 1'b0));
		send_item(build_item(KIND_SET_SHOW, 6'd0, 6'd63, 16'hFFFF, 16'hFFFF, ST_BAD, 1'b1));
		send_item(build_item(KIND_SET_POS, 6'd1, 6'd0, 16'd107, 16'd207, ST_SQUARE, 1'b1));
		send_item(build_item(KIND_SET_SHOW, 6'd1, 6'd0, 16'd0, 16'd0, ST_SQUARE, 1'b1));
		// corners touch exactly
		send_item(build_item(KIND_QUERY, 6'd0, 6'd1, 16'd0, 16'd0, ST_SQUARE, 1'b0));
		send_item(build_item(KIND_SET_POS, 6'd1, 6'd0, 16'd108, 16'd200, ST_SQUARE, 1'b0));
		send_item(build_item(KIND_QUERY, 6'd1, 6'd0, 16'd0, 16'd0, ST_SQUARE, 1'b0));
		send_item(build_item(KIND_SET_TYPE, 6'd0, 6'd1, 16'd0, 16'd0, ST_WIDE, 1'b0));
		send_item(build_item(KIND_QUERY, 6'd1, 6'd0, 16'd0, 16'd0, ST_SQUARE, 1'b0));
	endtask

	task automatic test_wrap_and_self();
		send_item(build_item(KIND_SET_POS, 6'd2, 6'd0, 16'hFFFF, 16'hFFFF, ST_BIG, 1'b0));
		send_item(build_item(KIND_SET_TYPE, 6'd2, 6'd0, 16'h0000, 16'h0000, ST_BIG, 1'b0));
		send_item(build_item(KIND_SET_SHOW, 6'd2, 6'd0, 16'h0000, 16'h0000, ST_TALL, 1'b1));
		send_item(build_item(KIND_QUERY, 6'd2, 6'd2, 16'h0000, 16'h0000, ST_SQUARE, 1'b0));
		send_item(build_item(KIND_SET_POS, 6'd2, 6'd0, 16'hFFF0, 16'hFFF0, ST_BIG, 1'b0));
		send_item(build_item(KIND_QUERY, 6'd2, 6'd2, 16'h0000, 16'h0000, ST_SQUARE, 1'b0));
	endtask

	task automatic test_unknown_type();
		send_item(build_item(KIND_SET_TYPE, 6'd3, 6'd0, 16'h0000, 16'h0000, ST_BAD, 1'b1));
		send_item(build_item(KIND_QUERY, 6'd3, 6'd0, 16'h0000, 16'h0000, ST_SQUARE, 1'b0));
		send_item(build_item(KIND_SET_SHOW, 6'd3, 6'd0, 16'h0000, 16'h0000, ST_SQUARE, 1'b1));
		send_item(build_item(KIND_SET_SHOW, 6'd0, 6'd3, 16'hFFFF, 16'hFFFF, ST_BAD, 1'b0));
		send_item(build_item(KIND_QUERY, 6'd0, 6'd3, 16'h0000, 16'h0000, ST_SQUARE, 1'b1));
	endtask

	task automatic test_random_traffic(input int count);
		for (int i = 0; i < count; i++)
			send_item(random_item());
	endtask

	task automatic test_drain_pause();
		stop_sending();
		wait_drained();
		repeat ($urandom_range(1, 6)) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		item   = '0;
		error_count  = 0;
		items_sent   = 0;
		queries_sent = 0;
		hits_seen    = 0;
		bad_seen     = 0;
		for (int i = 0; i < SLOTS; i++) begin
			tab_x[i]    = '0;
			tab_y[i]    = '0;
			tab_type[i] = '0;
			tab_vis[i]  = 1'b0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_after_reset();
		test_box_edges();
		test_wrap_and_self();
		test_unknown_type();
		test_random_traffic(RAND_ITEMS / 2);
		test_drain_pause();
		test_random_traffic(RAND_ITEMS - RAND_ITEMS / 2);
		stop_sending();
		wait_drained();
		repeat (10) @(posedge clk);

		$display("%0d items sent, %0d of them queries", items_sent, queries_sent);
		$display("%0d collisions and %0d unknown type flags seen", hits_seen, bad_seen);
		if (error_count == 0 && expected_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
